### hw/rtl/gbn_pkg.sv
package gbn_pkg;

  localparam int unsigned SEQ_W  = 32;
  localparam int unsigned TMR_W  = 16;
  localparam int unsigned WIN_W  = 5;
  localparam int unsigned RTY_W  = 8;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 5;

  // Largest window the sender supports
  localparam logic [WIN_W-1:0] MAX_WIN = 5'd16;

  // Request opcodes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_ACK   = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Packet kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_FIN  = 1'b1;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_CHUNK_COUNT    = 3'd0;
  localparam logic [2:0] REG_INITIAL_WINDOW = 3'd1;
  localparam logic [2:0] REG_MIN_WINDOW     = 3'd2;
  localparam logic [2:0] REG_MAX_WINDOW     = 3'd3;
  localparam logic [2:0] REG_TIMEOUT_TICKS  = 3'd4;
  localparam logic [2:0] REG_MAX_RETRIES    = 3'd5;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_DATA = 3'd1,
    PH_FIN  = 3'd2,
    PH_DONE = 3'd3,
    PH_FAIL = 3'd4
  } phase_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [SEQ_W-1:0] ack_seq;
  } in_req_t;

  typedef struct packed {
    logic             send_valid;
    logic             send_kind;
    logic [SEQ_W-1:0] send_seq;
    logic [2:0]       status;
    logic [WIN_W-1:0] window_now;
    logic             last;
  } out_req_t;

  typedef struct packed {
    logic [SEQ_W-1:0] chunk_count;
    logic [WIN_W-1:0] initial_window;
    logic [WIN_W-1:0] min_window;
    logic [WIN_W-1:0] max_window;
    logic [TMR_W-1:0] timeout_ticks;
    logic [RTY_W-1:0] max_retries;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic start_init;
    logic ack_clamp;
    logic ack_adv;
    logic fin_done;
    logic fail;
    logic fin_send;
    logic fin_enter;
    logic tick_inc;
    logic rexmit;
    logic fill_lim;
    logic fill_set;
    logic emit_data;
    logic emit_fin;
    logic emit_none;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    phase_t     phase;
    logic       ack_ok;
    logic       ack_match;
    logic       adv;
    logic       expired;
    logic       retry_hit;
    logic       fin_ready;
    logic       have_send;
    logic       cur_last;
    logic       out_free;
  } dp_stat_t;

  function automatic logic [WIN_W-1:0] eff_max(input logic [WIN_W-1:0] m);
    logic [WIN_W-1:0] r;
    r = m;
    if (r == '0) r = WIN_W'(1);
    if (r > MAX_WIN) r = MAX_WIN;
    return r;
  endfunction

  function automatic logic [WIN_W-1:0] eff_min(input logic [WIN_W-1:0] m,
                                               input logic [WIN_W-1:0] hi);
    logic [WIN_W-1:0] r;
    r = m;
    if (r == '0) r = WIN_W'(1);
    if (r > hi) r = hi;
    return r;
  endfunction

  function automatic logic [WIN_W-1:0] start_win(input logic [WIN_W-1:0] w,
                                                 input logic [WIN_W-1:0] lo,
                                                 input logic [WIN_W-1:0] hi);
    logic [WIN_W-1:0] r;
    r = w;
    if (r < lo) r = lo;
    if (r > hi) r = hi;
    return r;
  endfunction

endpackage

### hw/rtl/gbn_regs.sv
module gbn_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gbn_pkg::ADDR_W-1:0]   paddr,
  input  logic [gbn_pkg::DATA_W-1:0]   pwdata,
  output logic [gbn_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output gbn_pkg::cfg_t                cfg
);

  logic [2:0] idx;

  assign idx    = paddr[gbn_pkg::ADDR_W-1:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.chunk_count    <= '0;
      cfg.initial_window <= gbn_pkg::WIN_W'(4);
      cfg.min_window     <= gbn_pkg::WIN_W'(1);
      cfg.max_window     <= gbn_pkg::WIN_W'(16);
      cfg.timeout_ticks  <= gbn_pkg::TMR_W'(500);
      cfg.max_retries    <= gbn_pkg::RTY_W'(10);
    end else if (psel && penable && pwrite) begin
      case (idx)
        gbn_pkg::REG_CHUNK_COUNT:    cfg.chunk_count    <= pwdata[gbn_pkg::SEQ_W-1:0];
        gbn_pkg::REG_INITIAL_WINDOW: cfg.initial_window <= pwdata[gbn_pkg::WIN_W-1:0];
        gbn_pkg::REG_MIN_WINDOW:     cfg.min_window     <= pwdata[gbn_pkg::WIN_W-1:0];
        gbn_pkg::REG_MAX_WINDOW:     cfg.max_window     <= pwdata[gbn_pkg::WIN_W-1:0];
        gbn_pkg::REG_TIMEOUT_TICKS:  cfg.timeout_ticks  <= pwdata[gbn_pkg::TMR_W-1:0];
        gbn_pkg::REG_MAX_RETRIES:    cfg.max_retries    <= pwdata[gbn_pkg::RTY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      gbn_pkg::REG_CHUNK_COUNT:    prdata = gbn_pkg::DATA_W'(cfg.chunk_count);
      gbn_pkg::REG_INITIAL_WINDOW: prdata = gbn_pkg::DATA_W'(cfg.initial_window);
      gbn_pkg::REG_MIN_WINDOW:     prdata = gbn_pkg::DATA_W'(cfg.min_window);
      gbn_pkg::REG_MAX_WINDOW:     prdata = gbn_pkg::DATA_W'(cfg.max_window);
      gbn_pkg::REG_TIMEOUT_TICKS:  prdata = gbn_pkg::DATA_W'(cfg.timeout_ticks);
      gbn_pkg::REG_MAX_RETRIES:    prdata = gbn_pkg::DATA_W'(cfg.max_retries);
      default:                     prdata = '0;
    endcase
  end

endmodule

### hw/rtl/gbn_dp.sv
module gbn_dp (
  input  logic              clk,
  input  logic              rst,
  input  gbn_pkg::cfg_t     cfg,
  input  gbn_pkg::dp_cmd_t  cmd,
  output gbn_pkg::dp_stat_t stat,
  input  gbn_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output gbn_pkg::out_req_t out_data
);

  localparam int unsigned SW = gbn_pkg::SEQ_W;
  localparam int unsigned WW = gbn_pkg::WIN_W;
  localparam int unsigned TW = gbn_pkg::TMR_W;
  localparam int unsigned RW = gbn_pkg::RTY_W;

  // Sender state
  logic [SW-1:0]    base_seq;
  logic [SW-1:0]    next_seq;
  logic [WW-1:0]    window_size;
  logic [RW-1:0]    retry_count;
  logic             timer_running;
  logic [TW-1:0]    elapsed_ticks;
  gbn_pkg::phase_t  phase;

  // Work registers
  gbn_pkg::in_req_t req;
  logic [SW-1:0]    ack_cl;
  logic [SW-1:0]    cur;
  logic [SW-1:0]    lim;

  logic [WW-1:0]    eff_hi;
  logic [WW-1:0]    eff_lo;
  logic [SW:0]      win_sum;
  logic [SW-1:0]    lim_val;
  logic [SW-1:0]    ack_clamped;
  logic [WW:0]      win_inc;
  logic [WW-1:0]    win_grow;
  logic [WW-1:0]    win_shr;
  logic [WW-1:0]    win_half;
  logic [TW-1:0]    elapsed_inc;
  logic [SW-1:0]    cur_inc;
  logic             next_adv;
  logic             base_lt_next;
  logic             out_free;

  always_comb begin
    eff_hi      = gbn_pkg::eff_max(cfg.max_window);
    eff_lo      = gbn_pkg::eff_min(cfg.min_window, eff_hi);
    win_sum     = {1'b0, base_seq} + (SW+1)'(window_size);
    lim_val     = ({1'b0, cfg.chunk_count} < win_sum) ? cfg.chunk_count : win_sum[SW-1:0];
    ack_clamped = (req.ack_seq >= next_seq) ? (next_seq - SW'(1)) : req.ack_seq;
    win_inc     = {1'b0, window_size} + (WW+1)'(1);
    win_grow    = (win_inc > {1'b0, eff_hi}) ? eff_hi : win_inc[WW-1:0];
    win_shr     = window_size >> 1;
    win_half    = (win_shr < eff_lo) ? eff_lo : win_shr;
    elapsed_inc = (elapsed_ticks == '1) ? elapsed_ticks : (elapsed_ticks + TW'(1));
    cur_inc     = cur + SW'(1);
    next_adv    = next_seq < lim;
    base_lt_next = base_seq < next_seq;
    out_free    = !out_valid || out_ready;
  end

  always_comb begin
    stat.op        = req.op;
    stat.phase     = phase;
    stat.ack_ok    = (req.ack_seq != '1) && (next_seq != '0);
    stat.ack_match = req.ack_seq == cfg.chunk_count;
    stat.adv       = ack_cl >= base_seq;
    stat.expired   = timer_running && (elapsed_ticks >= cfg.timeout_ticks);
    stat.retry_hit = retry_count >= cfg.max_retries;
    stat.fin_ready = base_seq >= cfg.chunk_count;
    stat.have_send = cur < lim;
    stat.cur_last  = cur_inc == lim;
    stat.out_free  = out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_seq      <= '0;
      next_seq      <= '0;
      window_size   <= WW'(1);
      retry_count   <= '0;
      timer_running <= 1'b0;
      elapsed_ticks <= '0;
      phase         <= gbn_pkg::PH_IDLE;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.start_init) begin
        window_size   <= gbn_pkg::start_win(cfg.initial_window, eff_lo, eff_hi);
        base_seq      <= '0;
        next_seq      <= '0;
        retry_count   <= '0;
        timer_running <= 1'b0;
        elapsed_ticks <= '0;
        phase         <= gbn_pkg::PH_DATA;
      end
      if (cmd.ack_adv) begin
        base_seq      <= ack_cl + SW'(1);
        window_size   <= win_grow;
        retry_count   <= '0;
        timer_running <= 1'b0;
        elapsed_ticks <= '0;
      end
      if (cmd.fin_done) begin
        phase         <= gbn_pkg::PH_DONE;
        timer_running <= 1'b0;
      end
      if (cmd.fail) begin
        phase         <= gbn_pkg::PH_FAIL;
        timer_running <= 1'b0;
      end
      if (cmd.fin_send) begin
        retry_count   <= cmd.fin_enter ? RW'(1) : (retry_count + RW'(1));
        timer_running <= 1'b1;
        elapsed_ticks <= '0;
        if (cmd.fin_enter) phase <= gbn_pkg::PH_FIN;
      end
      if (cmd.tick_inc && timer_running) begin
        elapsed_ticks <= elapsed_inc;
      end
      if (cmd.rexmit) begin
        retry_count   <= retry_count + RW'(1);
        window_size   <= win_half;
        timer_running <= 1'b1;
        elapsed_ticks <= '0;
      end
      if (cmd.fill_set) begin
        if (next_adv) next_seq <= lim;
        if (!timer_running && (next_adv || base_lt_next)) begin
          timer_running <= 1'b1;
          elapsed_ticks <= '0;
        end
      end
      if (cmd.emit_data || cmd.emit_fin || cmd.emit_none) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) req <= in_data;
    if (cmd.ack_clamp) ack_cl <= ack_clamped;
    if (cmd.fill_lim) begin
      lim <= lim_val;
      cur <= next_seq;
    end
    if (cmd.rexmit) begin
      cur <= base_seq;
      lim <= next_seq;
    end
    if (cmd.emit_data) begin
      cur                 <= cur_inc;
      out_data.send_valid <= 1'b1;
      out_data.send_kind  <= gbn_pkg::KIND_DATA;
      out_data.send_seq   <= cur;
      out_data.last       <= cur_inc == lim;
    end
    if (cmd.emit_fin) begin
      out_data.send_valid <= 1'b1;
      out_data.send_kind  <= gbn_pkg::KIND_FIN;
      out_data.send_seq   <= cfg.chunk_count;
      out_data.last       <= 1'b1;
    end
    if (cmd.emit_none) begin
      out_data.send_valid <= 1'b0;
      out_data.send_kind  <= gbn_pkg::KIND_DATA;
      out_data.send_seq   <= '0;
      out_data.last       <= 1'b1;
    end
    if (cmd.emit_data || cmd.emit_fin || cmd.emit_none) begin
      out_data.status     <= phase;
      out_data.window_now <= window_size;
    end
  end

endmodule

### hw/rtl/gbn_ctrl.sv
module gbn_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  gbn_pkg::dp_stat_t stat,
  output gbn_pkg::dp_cmd_t  cmd
);

  typedef enum logic [8:0] {
    ST_IDLE      = 9'b000000001,
    ST_DECODE    = 9'b000000010,
    ST_ACK_CHK   = 9'b000000100,
    ST_TICK_CHK  = 9'b000001000,
    ST_FILL_LIM  = 9'b000010000,
    ST_FILL_SET  = 9'b000100000,
    ST_EMIT_RUN  = 9'b001000000,
    ST_EMIT_FIN  = 9'b010000000,
    ST_EMIT_NONE = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = state == ST_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (stat.op)
          gbn_pkg::OP_START: begin
            cmd.start_init = 1'b1;
            state_next     = ST_FILL_LIM;
          end
          gbn_pkg::OP_ACK: begin
            if (stat.phase == gbn_pkg::PH_DATA) begin
              if (stat.ack_ok) begin
                cmd.ack_clamp = 1'b1;
                state_next    = ST_ACK_CHK;
              end else begin
                state_next = ST_EMIT_NONE;
              end
            end else if (stat.phase == gbn_pkg::PH_FIN) begin
              if (stat.ack_match) begin
                cmd.fin_done = 1'b1;
                state_next   = ST_EMIT_NONE;
              end else if (stat.retry_hit) begin
                cmd.fail   = 1'b1;
                state_next = ST_EMIT_NONE;
              end else begin
                cmd.fin_send = 1'b1;
                state_next   = ST_EMIT_FIN;
              end
            end else begin
              state_next = ST_EMIT_NONE;
            end
          end
          gbn_pkg::OP_TICK: begin
            if (stat.phase == gbn_pkg::PH_DATA || stat.phase == gbn_pkg::PH_FIN) begin
              cmd.tick_inc = 1'b1;
              state_next   = ST_TICK_CHK;
            end else begin
              state_next = ST_EMIT_NONE;
            end
          end
          default: begin
            state_next = ST_EMIT_NONE;
          end
        endcase
      end
      ST_ACK_CHK: begin
        if (stat.adv) begin
          cmd.ack_adv = 1'b1;
          state_next  = ST_FILL_LIM;
        end else begin
          state_next = ST_EMIT_NONE;
        end
      end
      ST_TICK_CHK: begin
        if (!stat.expired) begin
          state_next = ST_EMIT_NONE;
        end else if (stat.retry_hit) begin
          cmd.fail   = 1'b1;
          state_next = ST_EMIT_NONE;
        end else if (stat.phase == gbn_pkg::PH_DATA) begin
          cmd.rexmit = 1'b1;
          state_next = ST_EMIT_RUN;
        end else begin
          cmd.fin_send = 1'b1;
          state_next   = ST_EMIT_FIN;
        end
      end
      ST_FILL_LIM: begin
        cmd.fill_lim = 1'b1;
        state_next   = ST_FILL_SET;
      end
      ST_FILL_SET: begin
        if (stat.fin_ready) begin
          cmd.fin_send  = 1'b1;
          cmd.fin_enter = 1'b1;
          state_next    = ST_EMIT_FIN;
        end else begin
          cmd.fill_set = 1'b1;
          state_next   = ST_EMIT_RUN;
        end
      end
      ST_EMIT_RUN: begin
        if (stat.out_free) begin
          if (stat.have_send) begin
            cmd.emit_data = 1'b1;
            if (stat.cur_last) state_next = ST_IDLE;
          end else begin
            cmd.emit_none = 1'b1;
            state_next    = ST_IDLE;
          end
        end
      end
      ST_EMIT_FIN: begin
        if (stat.out_free) begin
          cmd.emit_fin = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_EMIT_NONE: begin
        if (stat.out_free) begin
          cmd.emit_none = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/go_back_n_sender_aimd_top.sv
// Go-Back-N sender with AIMD window: one request at a time, N results each (N = 1..16).
// After decode, a no-op or FIN-phase ACK goes straight to the emit step; a tick or a non-advancing
// ACK first passes its check step; a start passes the fill steps, an advancing ACK the ACK check
// and then the fill steps. A new request is taken only once the last result of the one before has
// been emitted; after the first, results come one per cycle while the output is not stalled.
// Reset (rst, synchronous): settings and state reset, the sender goes idle; out_data is not reset.
module go_back_n_sender_aimd_top (
  input  logic                         clk,
  input  logic                         rst,
  // Request channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  gbn_pkg::in_req_t             in_data,
  // Result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output gbn_pkg::out_req_t            out_data,
  // Register port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gbn_pkg::ADDR_W-1:0]   paddr,
  input  logic [gbn_pkg::DATA_W-1:0]   pwdata,
  output logic [gbn_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  gbn_pkg::cfg_t     cfg;
  gbn_pkg::dp_cmd_t  cmd;
  gbn_pkg::dp_stat_t stat;

  // Hold transfer settings; write them only while the sender is quiet, which the block does not enforce.
  gbn_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequence each request: decode, check the ACK or timer, size the window fill,
  // then step the send cursor once per accepted result.
  gbn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Keep base/next sequence, window, retries and timer; drive the output register.
  // Status and window on every result reflect the state after the whole request.
  gbn_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
